### src/hjbp_pkg.sv
// Package: shared constants, codes and types of the hash join build/probe engine.
`timescale 1ns / 1ps
package hjbp_pkg;

    localparam int KEY_W        = 32;
    localparam int TAG_W        = 16;
    localparam int ROW_OUT_W    = 6;
    localparam int OP_W         = 2;
    localparam int GROUP_W      = 8;
    localparam int MAX_ROWS_DEF = 64;
    localparam int KEY_BITS_DEF = 32;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_PROBE  = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    // status from the match emitter to the sequencer
    typedef struct packed {
        logic fire;
        logic last;
        logic done;
    } t_emit_ctl;

endpackage

### src/hjbp_if.sv
// Interfaces: request and result channels with valid/ready handshake.
`timescale 1ns / 1ps
interface hjbp_in_if;
    logic                            valid;
    logic                            ready;
    logic [hjbp_pkg::OP_W-1:0]       operation;
    logic [hjbp_pkg::KEY_W-1:0]      key;
    logic [hjbp_pkg::TAG_W-1:0]      probe_tag;

    modport source (output valid, operation, key, probe_tag, input ready);
    modport sink   (input valid, operation, key, probe_tag, output ready);
endinterface

interface hjbp_out_if;
    logic                            valid;
    logic                            ready;
    logic [hjbp_pkg::TAG_W-1:0]      match_tag;
    logic [hjbp_pkg::ROW_OUT_W-1:0]  build_row;
    logic                            last;
    logic                            overflow;

    modport source (output valid, match_tag, build_row, last, overflow, input ready);
    modport sink   (input valid, match_tag, build_row, last, overflow, output ready);
endinterface

### src/hjbp_cell.sv
// One table row: stored key, key compare and hit flag.
`timescale 1ns / 1ps
module hjbp_cell #(
    parameter int IDX   = 0,
    parameter int KW    = 32,
    parameter int CW    = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_ins,
    input  logic          i_probe,
    input  logic [KW-1:0] i_key,
    input  logic [CW-1:0] i_count,
    input  logic          i_clr,
    output logic          o_hit
);

    logic [KW-1:0] r_key;
    logic          r_hit;
    logic          w_mine;
    logic          w_live;

    assign w_mine = (i_count == CW'(IDX));
    assign w_live = (CW'(IDX) < i_count);

    always_ff @(posedge i_clk) begin
        if (i_ins && w_mine) begin
            r_key <= i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_probe) begin
            r_hit <= w_live && (r_key == i_key);
        end else if (i_clr) begin
            r_hit <= 1'b0;
        end
    end

    assign o_hit = r_hit;

endmodule

### src/hjbp_emit.sv
// Match emitter: walks the hit flags in groups of eight, lowest row first.
`timescale 1ns / 1ps
module hjbp_emit #(
    parameter int NGROUPS = 8,
    parameter int GW      = 3
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic                                   i_active,
    input  logic                                   i_out_free,
    input  logic [NGROUPS*hjbp_pkg::GROUP_W-1:0]   i_hits,
    output logic [NGROUPS*hjbp_pkg::GROUP_W-1:0]   o_clr,
    output logic [GW+2:0]                          o_row,
    output hjbp_pkg::t_emit_ctl                    o_ctl
);

    localparam int G    = hjbp_pkg::GROUP_W;
    localparam int NPAD = NGROUPS * G;

    logic [GW-1:0] r_grp;
    logic [GW-1:0] n_grp;
    logic [G-1:0]  w_bits;
    logic [2:0]    w_enc;
    logic [NPAD-1:0] w_sel;
    logic          w_any;

    always_comb begin
        w_bits = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            if (r_grp == GW'(g)) begin
                w_bits = i_hits[g*G +: G];
            end
        end
    end

    // lowest set bit of the current group
    always_comb begin
        w_enc = '0;
        for (int b = G - 1; b >= 0; b--) begin
            if (w_bits[b]) begin
                w_enc = 3'(b);
            end
        end
    end

    always_comb begin
        w_sel = '0;
        for (int g = 0; g < NGROUPS; g++) begin
            for (int b = 0; b < G; b++) begin
                w_sel[g*G + b] = (r_grp == GW'(g)) && (w_enc == 3'(b)) && w_bits[b];
            end
        end
    end

    assign w_any = |w_bits;
    assign o_ctl = '{fire: i_active && w_any && i_out_free,
                     last: ~|(i_hits & ~w_sel),
                     done: ~|i_hits};
    assign o_clr = o_ctl.fire ? w_sel : '0;
    assign o_row = {r_grp, w_enc};

    always_comb begin
        n_grp = r_grp;
        if (i_start) begin
            n_grp = '0;
        end else if (i_active && !w_any && (r_grp != GW'(NGROUPS - 1))) begin
            n_grp = r_grp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grp <= '0;
        end else begin
            r_grp <= n_grp;
        end
    end

endmodule

### src/hash_join_build_probe.sv
// Top level: hash join build/probe engine over a row of key cells.
//
//  channel | dir | handshake        | payload
//  i_req   | in  | valid/ready      | operation, key, probe_tag
//  o_rsp   | out | valid/ready      | match_tag, build_row, last, overflow
//
// Insert and clear are finished when accepted and keep the engine idle. A probe
// first compares the key in every cell into registered hit flags, then emits
// one result per match, walked by the emitter group by group of eight rows,
// lowest row first; a probe with no match ends its scan with no result.
// A stalled result register holds the walk in place.
// Synchronous active-low reset empties the table and clears the overflow flag.
// One request is worked on at a time; the next is taken once a probe's last
// result has moved into the output register.
`timescale 1ns / 1ps
module hash_join_build_probe #(
    parameter int MAX_ROWS = hjbp_pkg::MAX_ROWS_DEF,
    parameter int KEY_BITS = hjbp_pkg::KEY_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hjbp_in_if.sink           i_req,
    hjbp_out_if.source        o_rsp
);

    localparam int KW      = (KEY_BITS < hjbp_pkg::KEY_W) ? KEY_BITS : hjbp_pkg::KEY_W;
    localparam int CW      = $clog2(MAX_ROWS + 1);
    localparam int G       = hjbp_pkg::GROUP_W;
    localparam int NGROUPS = (MAX_ROWS + G - 1) / G;
    localparam int NPAD    = NGROUPS * G;
    localparam int GW      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;

    hjbp_pkg::t_state    r_state, n_state;
    hjbp_pkg::t_emit_ctl w_ctl;

    logic [CW-1:0]                 r_count;
    logic                          r_drop;
    logic [hjbp_pkg::TAG_W-1:0]    r_ptag;
    logic                          r_out_valid;
    logic [hjbp_pkg::TAG_W-1:0]    r_out_tag;
    logic [hjbp_pkg::ROW_OUT_W-1:0] r_out_row;
    logic                          r_out_last;
    logic                          r_out_ovf;

    logic            w_acc;
    logic            w_ins;
    logic            w_probe;
    logic            w_clear;
    logic            w_full;
    logic            w_free;
    logic [KW-1:0]   w_key;
    logic [NPAD-1:0] w_hits;
    logic [NPAD-1:0] w_clr;
    logic [GW+2:0]   w_row;

    assign i_req.ready = (r_state == hjbp_pkg::ST_IDLE);
    assign w_acc   = i_req.valid && i_req.ready;
    assign w_ins   = w_acc && (i_req.operation == hjbp_pkg::OP_INSERT);
    assign w_probe = w_acc && (i_req.operation == hjbp_pkg::OP_PROBE);
    assign w_clear = w_acc && (i_req.operation == hjbp_pkg::OP_CLEAR);
    assign w_full  = (r_count == CW'(MAX_ROWS));
    assign w_key   = i_req.key[KW-1:0];
    // output register is free when empty or being taken this cycle
    assign w_free  = !r_out_valid || o_rsp.ready;

    // row of cells, one per table row
    for (genvar i = 0; i < NPAD; i++) begin : g_row
        if (i < MAX_ROWS) begin : g_cell
            hjbp_cell #(
                .IDX (i),
                .KW  (KW),
                .CW  (CW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ins   (w_ins && !w_full),
                .i_probe (w_probe),
                .i_key   (w_key),
                .i_count (r_count),
                .i_clr   (w_clr[i]),
                .o_hit   (w_hits[i])
            );
        end else begin : g_pad
            assign w_hits[i] = 1'b0;
        end
    end

    hjbp_emit #(
        .NGROUPS (NGROUPS),
        .GW      (GW)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_probe),
        .i_active   (r_state == hjbp_pkg::ST_SCAN),
        .i_out_free (w_free),
        .i_hits     (w_hits),
        .o_clr      (w_clr),
        .o_row      (w_row),
        .o_ctl      (w_ctl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hjbp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hjbp_pkg::ST_IDLE: begin
                if (w_probe) begin
                    n_state = hjbp_pkg::ST_SCAN;
                end
            end
            hjbp_pkg::ST_SCAN: begin
                if (w_ctl.done || (w_ctl.fire && w_ctl.last)) begin
                    n_state = hjbp_pkg::ST_IDLE;
                end
            end
            default: n_state = hjbp_pkg::ST_IDLE;
        endcase
    end

    // row count and sticky overflow
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else if (w_clear) begin
            r_count <= '0;
            r_drop  <= 1'b0;
        end else if (w_ins) begin
            if (w_full) begin
                r_drop <= 1'b1;
            end else begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_probe) begin
            r_ptag <= i_req.probe_tag;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.fire) begin
            r_out_tag  <= r_ptag;
            r_out_row  <= hjbp_pkg::ROW_OUT_W'(w_row);
            r_out_last <= w_ctl.last;
            r_out_ovf  <= r_drop;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.match_tag = r_out_tag;
    assign o_rsp.build_row = r_out_row;
    assign o_rsp.last      = r_out_last;
    assign o_rsp.overflow  = r_out_ovf;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ROWS))
        else $error("row count beyond table size");

    a_fire_clears_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.fire |=> $countones(w_hits) == $past($countones(w_hits)) - 1)
        else $error("emitted match did not retire exactly one hit");

    a_last_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.fire && w_ctl.last) |=> r_state == hjbp_pkg::ST_IDLE)
        else $error("scan continued after last match");

    a_empty_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hjbp_pkg::ST_SCAN && w_ctl.done) |=> r_state == hjbp_pkg::ST_IDLE)
        else $error("scan stuck with no hits left");

    a_drop_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_drop) |-> $past(w_ins && w_full))
        else $error("overflow set without a dropped insert");

endmodule
